### hdl/cidpq_pkg.sv
// Package with types, codes and helper functions for the CAN identifier priority transmit queue.
`default_nettype none

package cidpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int ID_W            = 11;
    localparam int LEN_W           = 4;
    localparam int DATA_W          = 64;
    localparam int OCC_W           = 5;
    localparam int MAX_LEN         = 8;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 88;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_CMP,
        ST_PUSH_PUT,
        ST_POP_SHIFT,
        ST_RESULT
    } state_t;

    function automatic logic [DATA_W-1:0] format_payload(
        input logic [DATA_W-1:0] data,
        input logic [LEN_W-1:0]  len,
        input logic              reverse
    );
        logic [DATA_W-1:0] res;
        logic [LEN_W-1:0]  src;
        res = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            if (LEN_W'(i) < len) begin
                src = reverse ? (len - LEN_W'(1) - LEN_W'(i)) : LEN_W'(i);
                res[8*i +: 8] = data[8*src[2:0] +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/can_id_priority_tx_queue_core.sv
// Top level of the CAN transmit queue kept sorted by identifier in a single-port-write memory.
// Query, rejected enqueue and remove with at most one frame held go straight to the output
// register; remove with two or more frames shifts the rest down; enqueue into an empty queue
// writes the frame directly, else frames at or above the new identifier move up first, as the
// insertion walks the memory one entry per cycle. No new transaction is taken until the
// result is registered. Synchronous active-low reset empties the queue; memory is not cleared.
`default_nettype none

module can_id_priority_tx_queue_core
    import cidpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // frame_id, frame_len, frame_data, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status, head_valid, head_id, head_len, head_payload, occupancy, zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    slot_t  slot_mem [QUEUE_DEPTH];
    slot_t  rd_data_reg;
    logic   mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    slot_t  mem_wdata;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    slot_t  head_reg, head_next;
    slot_t  in_reg, in_next;
    logic [1:0] stat_reg, stat_next;
    logic   msb_first_reg;
    logic   m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic s_fire, out_load, shift_go, pop_last;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] idx_m1, idx_p1;
    logic [LEN_W-1:0] len_clamp;
    logic [1:0] func;

    assign func      = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);
    assign count_m1  = count_reg - CW'(1);
    assign idx_m1    = idx_reg - AW'(1);
    assign idx_p1    = idx_reg + AW'(1);
    assign shift_go  = (rd_data_reg.id >= in_reg.id);
    assign pop_last  = (CW'(idx_reg) + CW'(2) == count_reg);
    assign len_clamp = (s_tdata[14:11] > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : s_tdata[14:11];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (func == FUNC_PUSH) begin
                        if (CW'(QUEUE_DEPTH) == count_reg) begin
                            state_next = ST_RESULT;
                        end else if (count_reg == '0) begin
                            state_next = ST_PUSH_PUT;
                        end else begin
                            state_next = ST_PUSH_CMP;
                        end
                    end else if (func == FUNC_POP && count_reg > CW'(1)) begin
                        state_next = ST_POP_SHIFT;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_PUSH_CMP: begin
                if (!shift_go || idx_reg == AW'(1)) begin
                    state_next = ST_PUSH_PUT;
                end
            end
            ST_PUSH_PUT: state_next = ST_RESULT;
            ST_POP_SHIFT: begin
                if (pop_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        in_next    = in_reg;
        stat_next  = stat_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = rd_data_reg;
        mem_re     = 1'b0;
        mem_raddr  = idx_m1;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    in_next.id   = s_tdata[10:0];
                    in_next.len  = len_clamp;
                    in_next.data = s_tdata[78:15];
                    stat_next    = STAT_DONE;
                    if (func == FUNC_PUSH) begin
                        if (CW'(QUEUE_DEPTH) == count_reg) begin
                            stat_next = STAT_FULL;
                        end else begin
                            idx_next  = count_reg[AW-1:0];
                            mem_re    = (count_reg != '0);
                            mem_raddr = count_m1[AW-1:0];
                        end
                    end else if (func == FUNC_POP) begin
                        if (count_reg == '0) begin
                            stat_next = STAT_EMPTY;
                        end else if (count_reg == CW'(1)) begin
                            count_next = '0;
                        end else begin
                            idx_next  = '0;
                            mem_re    = 1'b1;
                            mem_raddr = AW'(1);
                        end
                    end
                end
            end
            ST_PUSH_CMP: begin
                if (shift_go) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_m1;
                    if (idx_reg != AW'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_m1 - AW'(1);
                    end
                end
            end
            ST_PUSH_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = in_reg;
                count_next = count_reg + CW'(1);
                if (idx_reg == '0) begin
                    head_next = in_reg;
                end
            end
            ST_POP_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = rd_data_reg;
                if (idx_reg == '0) begin
                    head_next = rd_data_reg;
                end
                if (pop_last) begin
                    count_next = count_m1;
                end else begin
                    idx_next  = idx_p1;
                    mem_re    = 1'b1;
                    mem_raddr = idx_p1 + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            msb_first_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                msb_first_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        head_reg <= head_next;
        in_reg   <= in_next;
        stat_reg <= stat_next;
        if (out_load) begin
            if (count_reg != '0) begin
                m_tdata_reg <= {1'b0, OCC_W'(count_reg),
                                format_payload(head_reg.data, head_reg.len, msb_first_reg),
                                head_reg.len, head_reg.id, 1'b1, stat_reg};
            end else begin
                m_tdata_reg <= {1'b0, OCC_W'(count_reg), DATA_W'(0), LEN_W'(0),
                                ID_W'(0), 1'b0, stat_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && func == FUNC_POP && count_reg == '0)
        |=> (state_reg == ST_RESULT && stat_reg == STAT_EMPTY && count_reg == '0))
        else $error("remove on empty queue not reported");

    a_pop_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_SHIFT) |-> (CW'(idx_reg) + CW'(1) < count_reg))
        else $error("remove shift index out of range");

    a_push_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH_CMP) |-> (idx_reg != '0 && CW'(idx_reg) <= count_reg))
        else $error("insert walk index out of range");

    a_full_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && func == FUNC_PUSH && count_reg == CW'(QUEUE_DEPTH))
        |=> (stat_reg == STAT_FULL && $stable(count_reg)))
        else $error("rejected enqueue changed the queue");

endmodule

`default_nettype wire
